// ----- src/b64c_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64c_pkg
// Shared types and constants of the base64 codec with a programmable alphabet.
// ============================================================================
package b64c_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int ALPHA_CHARS = 64;
    localparam int CFG_REGS    = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int GROUP_W     = 18;
    localparam int MAX_RES     = 4;
    localparam int RES_CNT_W   = 3;
    localparam int RES_POS_W   = 2;

    localparam logic [BYTE_W-1:0] PAD_CHAR_DEFAULT = 8'd61;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    typedef logic [ALPHA_CHARS-1:0][BYTE_W-1:0] alpha_t;
    typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] cfg_bank_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]            cnt;
        logic [MAX_RES-1:0][BYTE_W-1:0] data;
        logic                            last;
        logic                            bare;
        logic [1:0]                      status;
    } res_t;

endpackage

// ----- src/b64c_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64c_core
// Message state and the single-pass encode/decode step for one input beat.
// ============================================================================
module b64c_core #(
    parameter logic [7:0] PAD_CHAR = b64c_pkg::PAD_CHAR_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [b64c_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_last,
    input  b64c_pkg::alpha_t              alphabet,
    output b64c_pkg::res_t                res
);
    import b64c_pkg::*;

    localparam logic [1:0] CHARS_SAT = 2'd2;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;
    localparam logic [1:0] FILL_FULL = 2'd3;

    logic [GROUP_W-1:0] group_bits_reg, group_bits_next;
    logic [1:0]         group_fill_reg, group_fill_next;
    logic               message_mode_reg, message_mode_next;
    logic               in_message_reg, in_message_next;
    logic               pad_seen_reg, pad_seen_next;
    logic [1:0]         chars_seen_reg, chars_seen_next;
    logic               bad_char_seen_reg, bad_char_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg    <= '0;
            group_fill_reg    <= '0;
            message_mode_reg  <= MODE_ENCODE;
            in_message_reg    <= 1'b0;
            pad_seen_reg      <= 1'b0;
            chars_seen_reg    <= '0;
            bad_char_seen_reg <= 1'b0;
        end
        else
        begin
            group_bits_reg    <= group_bits_next;
            group_fill_reg    <= group_fill_next;
            message_mode_reg  <= message_mode_next;
            in_message_reg    <= in_message_next;
            pad_seen_reg      <= pad_seen_next;
            chars_seen_reg    <= chars_seen_next;
            bad_char_seen_reg <= bad_char_seen_next;
        end
    end

    // The lowest matching alphabet index wins; an unknown character maps to 63.
    logic             found;
    logic [IDX_W-1:0] dec_idx;

    always_comb
    begin
        found   = 1'b0;
        dec_idx = '1;
        for (int i = ALPHA_CHARS - 1; i >= 0; i--)
        begin
            if (alphabet[i] == in_byte)
            begin
                found   = 1'b1;
                dec_idx = IDX_W'(i);
            end
        end
    end

    logic               cur_mode;
    logic               is_pad;
    logic [23:0]        enc_n;
    logic               enc_emit;
    logic               enc_pad3;
    logic [GROUP_W-1:0] shift_bits;
    logic [1:0]         shift_fill;
    logic               flush_en;
    logic [GROUP_W-1:0] flush_bits;
    logic [1:0]         flush_fill;

    always_comb
    begin
        group_bits_next    = group_bits_reg;
        group_fill_next    = group_fill_reg;
        message_mode_next  = message_mode_reg;
        in_message_next    = in_message_reg;
        pad_seen_next      = pad_seen_reg;
        chars_seen_next    = chars_seen_reg;
        bad_char_seen_next = bad_char_seen_reg;
        res                = '0;
        cur_mode           = in_message_reg ? message_mode_reg : mode;
        is_pad             = (in_byte == PAD_CHAR);
        enc_n              = '0;
        enc_emit           = 1'b0;
        enc_pad3           = 1'b0;
        shift_bits         = '0;
        shift_fill         = '0;
        flush_en           = 1'b0;
        flush_bits         = group_bits_reg;
        flush_fill         = group_fill_reg;

        if (accept)
        begin
            in_message_next   = 1'b1;
            message_mode_next = cur_mode;

            if (cur_mode == MODE_ENCODE)
            begin
                if (group_fill_reg >= FILL_TWO)
                begin
                    enc_n           = {group_bits_reg[15:0], in_byte};
                    enc_emit        = 1'b1;
                    group_bits_next = '0;
                    group_fill_next = '0;
                end
                else
                begin
                    shift_bits      = {group_bits_reg[9:0], in_byte};
                    shift_fill      = group_fill_reg + 2'd1;
                    group_bits_next = shift_bits;
                    group_fill_next = shift_fill;
                    if (in_last)
                    begin
                        enc_emit = 1'b1;
                        enc_pad3 = (shift_fill == FILL_ONE);
                        enc_n    = enc_pad3 ? {shift_bits[7:0], 16'd0}
                                            : {shift_bits[15:0], 8'd0};
                    end
                end
                if (enc_emit)
                begin
                    res.cnt     = RES_CNT_W'(MAX_RES);
                    res.data[0] = alphabet[enc_n[23:18]];
                    res.data[1] = alphabet[enc_n[17:12]];
                    res.data[2] = enc_pad3 ? PAD_CHAR : alphabet[enc_n[11:6]];
                    res.data[3] = in_last ? PAD_CHAR : alphabet[enc_n[5:0]];
                    if (group_fill_reg >= FILL_TWO)
                    begin
                        res.data[3] = alphabet[enc_n[5:0]];
                    end
                end
            end
            else
            begin
                chars_seen_next    = (chars_seen_reg == CHARS_SAT) ? CHARS_SAT
                                                                   : chars_seen_reg + 2'd1;
                bad_char_seen_next = bad_char_seen_reg | (!is_pad && !found);

                if (!pad_seen_reg)
                begin
                    if (is_pad)
                    begin
                        pad_seen_next = 1'b1;
                        flush_en      = 1'b1;
                    end
                    else if (group_fill_reg == FILL_FULL)
                    begin
                        res.cnt         = 3'd3;
                        res.data[0]     = group_bits_reg[17:10];
                        res.data[1]     = group_bits_reg[9:2];
                        res.data[2]     = {group_bits_reg[1:0], dec_idx};
                        group_bits_next = '0;
                        group_fill_next = '0;
                    end
                    else
                    begin
                        shift_bits      = {group_bits_reg[11:0], dec_idx};
                        shift_fill      = group_fill_reg + 2'd1;
                        group_bits_next = shift_bits;
                        group_fill_next = shift_fill;
                        if (in_last)
                        begin
                            flush_en   = 1'b1;
                            flush_bits = shift_bits;
                            flush_fill = shift_fill;
                        end
                    end
                end

                if (flush_en)
                begin
                    if (flush_fill == FILL_FULL)
                    begin
                        res.cnt         = 3'd2;
                        res.data[0]     = flush_bits[17:10];
                        res.data[1]     = flush_bits[9:2];
                        group_bits_next = '0;
                        group_fill_next = '0;
                    end
                    else if (flush_fill == FILL_TWO)
                    begin
                        res.cnt         = 3'd1;
                        res.data[0]     = flush_bits[11:4];
                        group_bits_next = '0;
                        group_fill_next = '0;
                    end
                end

                if (in_last)
                begin
                    if (chars_seen_next != CHARS_SAT)
                    begin
                        res.status = ST_SHORT;
                    end
                    else if (bad_char_seen_next)
                    begin
                        res.status = ST_BAD_CHAR;
                    end
                    else if (group_fill_next == FILL_ONE)
                    begin
                        res.status = ST_SHORT;
                    end
                    else
                    begin
                        res.status = ST_OK;
                    end
                end
            end

            if (in_last)
            begin
                res.last = 1'b1;
                if (res.cnt == '0)
                begin
                    res.cnt  = 3'd1;
                    res.bare = 1'b1;
                end
                group_bits_next    = '0;
                group_fill_next    = '0;
                in_message_next    = 1'b0;
                pad_seen_next      = 1'b0;
                chars_seen_next    = '0;
                bad_char_seen_next = 1'b0;
            end
        end
    end

endmodule

// ----- src/b64c_emit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64c_emit
// Holds the result beats of one input item; sends one a cycle unless stalled.
// ============================================================================
module b64c_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  b64c_pkg::res_t                res,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [b64c_pkg::BYTE_W-1:0]   out_byte,
    output logic                          has_byte,
    output logic                          out_last,
    output logic [1:0]                    status
);
    import b64c_pkg::*;

    logic [RES_CNT_W-1:0]            cnt_reg;
    logic [RES_POS_W-1:0]            pos_reg;
    logic [MAX_RES-1:0][BYTE_W-1:0] data_reg;
    logic                            last_reg;
    logic                            bare_reg;
    logic [1:0]                      status_reg;
    logic                            final_beat;
    logic                            fire;
    logic                            do_load;

    assign out_valid  = (cnt_reg != '0);
    assign final_beat = ({1'b0, pos_reg} + 3'd1) == cnt_reg;
    assign fire       = out_valid && !out_stall;
    assign free       = !out_valid || (fire && final_beat);
    assign do_load    = load && free && (res.cnt != '0);

    assign out_byte = data_reg[pos_reg];
    assign has_byte = !bare_reg;
    assign out_last = last_reg && final_beat;
    assign status   = out_last ? status_reg : ST_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (do_load)
        begin
            cnt_reg <= res.cnt;
            pos_reg <= '0;
        end
        else if (fire)
        begin
            if (final_beat)
            begin
                cnt_reg <= '0;
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            data_reg   <= res.data;
            last_reg   <= res.last;
            bare_reg   <= res.bare;
            status_reg <= res.status;
        end
    end

endmodule

// ----- src/base64_codec_custom_alphabet_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// base64_codec_custom_alphabet_top
// Streaming base64 encoder and decoder with a programmable 64-entry alphabet.
// ============================================================================
// Channel | Handshake                   | Beat fields
// in      | in_valid / in_stall         | mode, in_byte, in_last
// out     | out_valid / out_stall       | out_byte, has_byte, out_last, status
// cfg     | cfg_we                      | cfg_index, cfg_data
//
// An input beat is processed in the cycle it is accepted and its results appear
// on the output the next cycle, one beat per cycle from the result buffer
// while out_stall is low. A new input beat is taken as soon as the buffer's
// final beat leaves, so the result buffer sets the rate at which input beats
// are taken. Reset clears the message state, the alphabet and the buffer;
// out_stall holds the current beat, and in_stall stays high while the buffer
// holds a beat that is not leaving.
// ============================================================================
module base64_codec_custom_alphabet_top #(
    parameter logic [7:0] PAD_CHAR = b64c_pkg::PAD_CHAR_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [b64c_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [b64c_pkg::BYTE_W-1:0]       out_byte,
    output logic                              has_byte,
    output logic                              out_last,
    output logic [1:0]                        status,
    input  logic                              cfg_we,
    input  logic [b64c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [b64c_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import b64c_pkg::*;

    cfg_bank_t alpha_reg;
    alpha_t    alphabet;
    res_t      res;
    logic      free;
    logic      accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
        end
        else if (cfg_we)
        begin
            alpha_reg[cfg_index] <= cfg_data;
        end
    end

    assign alphabet = alpha_t'(alpha_reg);
    assign in_stall = !free;
    assign accept   = in_valid && free;

    b64c_core #(
        .PAD_CHAR (PAD_CHAR)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (mode),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .alphabet (alphabet),
        .res      (res)
    );

    b64c_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last),
        .status    (status)
    );

`ifndef SYNTHESIS
    a_no_result_leaves_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (res.cnt == '0)) |=> !out_valid)
        else $error("buffer not empty after a beat with no results");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> out_valid)
        else $error("closing beat produced no result");

    a_bare_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_byte) |-> out_last)
        else $error("bare end marker without out_last");

    a_status_final_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (status == ST_OK))
        else $error("status reported on a non-final beat");
`endif

endmodule

// ----- tb/base64_codec_custom_alphabet_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// base64_codec_custom_alphabet_top_tb
// Self-checking testbench for the streaming base64 codec.
// A directed table covers the reset alphabet, the byte extremes, short and
// full groups, pads, invalid and dangling characters. Random messages follow,
// under several alphabet settings including all-zero, all-one and one that
// holds the pad character and duplicates. Every accepted input beat runs
// through a behavioral predictor, and every output beat is compared field by
// field against the oldest predicted beat, with random gaps and stalls.
// ============================================================================
module base64_codec_custom_alphabet_top_tb;

    import b64c_pkg::*;

    localparam logic [7:0] PAD = PAD_CHAR_DEFAULT;
    localparam int DIR_ROWS = 26;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic [1:0] st;
    } beat_t;

    typedef enum {ROW_BEAT, ROW_STD_ALPHA} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic       m;
        logic [7:0] b;
        logic       lst;
        bit         typed;
        logic       has;
        logic [1:0] st;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic [BYTE_W-1:0]     in_byte;
    logic                  in_last;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_W-1:0]     out_byte;
    logic                  has_byte;
    logic                  out_last;
    logic [1:0]            status;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state.
    logic [7:0]  alphabet [64];
    logic [17:0] acc_bits;
    int          acc_count;
    logic        cur_mode;
    logic        busy_msg;
    logic        pad_hit;
    int          char_count;
    logic        bad_hit;
    int          step_count;

    beat_t       due_beats [$];
    beat_t       want_beat;
    logic [7:0]  msg_chars [$];
    logic [63:0] next_regs [8];

    bit          row_typed;
    logic        row_has;
    logic [1:0]  row_st;

    int tx_max = 4;
    int rx_max = 4;
    int items_sent = 0;
    int beats_checked = 0;
    int enc_msgs = 0;
    int dec_msgs = 0;
    int alpha_loads = 0;
    int errors = 0;

    row_t dir_rows [DIR_ROWS] = '{
        '{ROW_BEAT,      MODE_DECODE, 8'h00, 1'b1, 1'b1, 1'b0, ST_SHORT},
        '{ROW_STD_ALPHA, MODE_ENCODE, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'h80, 1'b1, 1'b1, 1'b1, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'hFF, 1'b1, 1'b1, 1'b1, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'h01, 1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, 8'hFE, 1'b1, 1'b1, 1'b1, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "A",   1'b1, 1'b1, 1'b0, ST_SHORT},
        '{ROW_BEAT,      MODE_DECODE, "T",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_ENCODE, "W",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "F",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "u",   1'b1, 1'b1, 1'b1, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "T",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "W",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, PAD,   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, PAD,   1'b1, 1'b1, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "T",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "W",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "F",   1'b1, 1'b1, 1'b1, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "T",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, PAD,   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, "*",   1'b1, 1'b1, 1'b0, ST_BAD_CHAR},
        '{ROW_BEAT,      MODE_DECODE, "T",   1'b0, 1'b0, 1'b0, ST_OK},
        '{ROW_BEAT,      MODE_DECODE, PAD,   1'b1, 1'b1, 1'b0, ST_SHORT},
        '{ROW_BEAT,      MODE_DECODE, PAD,   1'b1, 1'b1, 1'b0, ST_SHORT}
    };

    base64_codec_custom_alphabet_top #(
        .PAD_CHAR (PAD)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void emit_beat(input logic [7:0] b, input logic has);
        beat_t e;
        e = '{data: b, has: has, last: 1'b0, st: ST_OK};
        due_beats = {due_beats, e};
        step_count++;
    endfunction

    function automatic void flush_short_group();
        if (acc_count == 2)
        begin
            emit_beat(acc_bits[11:4], 1'b1);
            acc_bits = '0;
            acc_count = 0;
        end
        else if (acc_count == 3)
        begin
            emit_beat(acc_bits[17:10], 1'b1);
            emit_beat(acc_bits[9:2], 1'b1);
            acc_bits = '0;
            acc_count = 0;
        end
    endfunction

    function automatic void codec_predict(input logic m, input logic [7:0] c, input logic lst);
        logic [23:0] n;
        logic [1:0]  st;
        logic        found;
        logic        is_pad;
        logic [5:0]  idx;
        beat_t       tail;
        st = ST_OK;
        step_count = 0;
        if (!busy_msg)
        begin
            cur_mode = m;
            busy_msg = 1'b1;
        end
        if (cur_mode == MODE_ENCODE)
        begin
            if (acc_count >= 2)
            begin
                n = {acc_bits[15:0], c};
                emit_beat(alphabet[n[23:18]], 1'b1);
                emit_beat(alphabet[n[17:12]], 1'b1);
                emit_beat(alphabet[n[11:6]], 1'b1);
                emit_beat(alphabet[n[5:0]], 1'b1);
                acc_bits = '0;
                acc_count = 0;
            end
            else
            begin
                acc_bits = {acc_bits[9:0], c};
                acc_count++;
                if (lst)
                begin
                    n = (acc_count == 1) ? {acc_bits[7:0], 16'h0000} : {acc_bits[15:0], 8'h00};
                    emit_beat(alphabet[n[23:18]], 1'b1);
                    emit_beat(alphabet[n[17:12]], 1'b1);
                    emit_beat((acc_count == 2) ? alphabet[n[11:6]] : PAD, 1'b1);
                    emit_beat(PAD, 1'b1);
                end
            end
        end
        else
        begin
            is_pad = (c == PAD);
            found = 1'b0;
            idx = 6'd63;
            for (int i = 0; i < 64; i++)
            begin
                if (!found && alphabet[i] == c)
                begin
                    found = 1'b1;
                    idx = 6'(i);
                end
            end
            if (char_count < 2)
                char_count++;
            if (!is_pad && !found)
                bad_hit = 1'b1;
            if (!pad_hit)
            begin
                if (is_pad)
                begin
                    pad_hit = 1'b1;
                    flush_short_group();
                end
                else if (acc_count == 3)
                begin
                    n = {acc_bits, idx};
                    emit_beat(n[23:16], 1'b1);
                    emit_beat(n[15:8], 1'b1);
                    emit_beat(n[7:0], 1'b1);
                    acc_bits = '0;
                    acc_count = 0;
                end
                else
                begin
                    acc_bits = {acc_bits[11:0], idx};
                    acc_count++;
                end
            end
            if (lst)
            begin
                if (!pad_hit)
                    flush_short_group();
                if (char_count < 2)
                    st = ST_SHORT;
                else if (bad_hit)
                    st = ST_BAD_CHAR;
                else if (acc_count == 1)
                    st = ST_SHORT;
                else
                    st = ST_OK;
            end
        end
        if (lst)
        begin
            if (step_count == 0)
                emit_beat(8'h00, 1'b0);
            tail = due_beats.pop_back();
            tail.last = 1'b1;
            tail.st = st;
            due_beats = {due_beats, tail};
            if (cur_mode == MODE_ENCODE)
                enc_msgs++;
            else
                dec_msgs++;
            acc_bits = '0;
            acc_count = 0;
            busy_msg = 1'b0;
            pad_hit = 1'b0;
            char_count = 0;
            bad_hit = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return alphabet[$urandom_range(0, 63)];
        else if (r < 8)
            return PAD;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void make_std_regs();
        string s;
        s = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        for (int i = 0; i < 64; i++)
            next_regs[i / 8][(i % 8) * 8 +: 8] = s[i];
    endfunction

    // Input acceptance: predict the output beats of every accepted beat.
    always @(posedge clk)
    begin
        beat_t fixed;
        if (rst_n && in_valid && !in_stall)
        begin
            codec_predict(mode, in_byte, in_last);
            if (row_typed && in_last)
            begin
                fixed = due_beats.pop_back();
                fixed.has = row_has;
                fixed.st = row_st;
                due_beats = {due_beats, fixed};
            end
        end
    end

    // Output check against the oldest predicted beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_beats.size() == 0)
            begin
                $display("%0t: output beat with nothing expected, got byte %0h has %0b last %0b",
                         $time, out_byte, has_byte, out_last);
                errors++;
            end
            else
            begin
                want_beat = due_beats.pop_front();
                check_field("out_byte", want_beat.data, out_byte);
                check_field("has_byte", want_beat.has, has_byte);
                check_field("out_last", want_beat.last, out_last);
                check_field("status", want_beat.st, status);
                beats_checked++;
            end
        end
    end

    // Receiver: a random stall, possibly none, ahead of every output beat.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, rx_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_beat(input logic m, input logic [7:0] b, input logic lst,
                             input bit typed, input logic has, input logic [1:0] st);
        int gap;
        gap = $urandom_range(0, tx_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        in_byte   <= b;
        in_last   <= lst;
        row_typed <= typed;
        row_has   <= has;
        row_st    <= st;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic load_alphabet();
        for (int i = 0; i < CFG_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= next_regs[i];
            for (int j = 0; j < 8; j++)
                alphabet[i * 8 + j] = next_regs[i][j * 8 +: 8];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        alpha_loads++;
    endtask

    task automatic random_message();
        int  n;
        int  nfull;
        int  tail;
        logic dec;
        msg_chars.delete();
        dec = 1'($urandom_range(0, 1));
        if (dec == MODE_ENCODE)
        begin
            n = $urandom_range(1, 8);
            repeat (n) msg_chars = {msg_chars, 8'($urandom_range(0, 255))};
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            nfull = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0: tail = 0;
                1: tail = 2;
                default: tail = 3;
            endcase
            if (nfull == 0 && tail == 0)
                tail = 2;
            repeat (4 * nfull + tail) msg_chars = {msg_chars, alphabet[$urandom_range(0, 63)]};
            if (tail != 0 && $urandom_range(0, 1) == 1)
                repeat (4 - tail) msg_chars = {msg_chars, PAD};
            if ($urandom_range(0, 7) == 0)
                msg_chars[$urandom_range(0, msg_chars.size() - 1)] = noise_char();
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) msg_chars = {msg_chars, noise_char()};
        end
        for (int i = 0; i < msg_chars.size(); i++)
        begin
            if (i > 0 && $urandom_range(0, 19) == 0)
                settle();
            send_beat((i == 0) ? dec : 1'($urandom_range(0, 1)), msg_chars[i],
                      (i == msg_chars.size() - 1), 1'b0, 1'b0, ST_OK);
        end
    endtask

    initial
    begin
        int goal;
        for (int i = 0; i < 64; i++)
            alphabet[i] = 8'h00;
        acc_bits   = '0;
        acc_count  = 0;
        cur_mode   = MODE_ENCODE;
        busy_msg   = 1'b0;
        pad_hit    = 1'b0;
        char_count = 0;
        bad_hit    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_ENCODE;
        in_byte    = '0;
        in_last    = 1'b0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        row_typed  = 1'b0;
        row_has    = 1'b0;
        row_st     = ST_OK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_STD_ALPHA)
            begin
                settle();
                make_std_regs();
                load_alphabet();
            end
            else
                send_beat(dir_rows[r].m, dir_rows[r].b, dir_rows[r].lst,
                          dir_rows[r].typed, dir_rows[r].has, dir_rows[r].st);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        next_regs[i] = {$urandom, $urandom};
                end
                1:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        next_regs[i] = '1;
                end
                2:
                begin
                    make_std_regs();
                    next_regs[0][3 * 8 +: 8] = PAD;
                    next_regs[1][2 * 8 +: 8] = next_regs[0][1 * 8 +: 8];
                end
                3:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        next_regs[i] = '0;
                end
                default:
                    make_std_regs();
            endcase
            load_alphabet();
            tx_max = (ph == 4) ? 0 : 4;
            rx_max = (ph == 4) ? 0 : 4;
            goal = items_sent + 28;
            while (items_sent < goal)
                random_message();
        end

        settle();
        $display("Sent %0d input beats in %0d encode and %0d decode messages under %0d alphabets,",
                 items_sent, enc_msgs, dec_msgs, alpha_loads);
        $display("and checked %0d output beats field by field.", beats_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d output beats still expected.", due_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
